### hdl/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

	localparam int IDX_W      = 10;
	localparam int CNT_W      = 6;
	// quotient bits of the tangent division, fraction bits of the normalise step, root digits
	localparam int DIV_STEPS  = 33;
	localparam int FRAC_STEPS = 28;
	localparam int ROOT_STEPS = 15;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_TRI    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DEGEN = 2'd1;
	localparam logic [1:0] STAT_ZERO  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_FETCH, S_DIFF, S_MUL, S_CHKDET, S_DINIT, S_DSTEP, S_DEND,
		S_ACC, S_SRD, S_SCAP, S_SQ, S_CHKLEN, S_NINIT, S_NSTEP, S_RINIT, S_RSTEP,
		S_REND, S_FINISH
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_LOAD, OP_FETCH, OP_LATCH, OP_DIFF, OP_MUL, OP_SUB,
		OP_DINIT, OP_DSTEP, OP_DEND, OP_ARD, OP_AWR, OP_SRD, OP_SCAP, OP_SQ, OP_LSUM,
		OP_NINIT, OP_NSTEP, OP_RINIT, OP_RSTEP, OP_REND, OP_SKIP, OP_ZERO, OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       a_ok;
		logic       tri_ok;
		logic       det_zero;
		logic       len_zero;
	} dp_stat_t;

endpackage
`default_nettype wire

### hdl/mtg_ctrl.sv
`default_nettype none
module mtg_ctrl
	import mtg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       dcmd,
	output logic          busy
);

	ctrl_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0] comp_q, comp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		dcmd.op = OP_NONE;
		dcmd.k  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dcmd.op = OP_CAPTURE;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cnt_d  = '0;
				comp_d = '0;
				case (stat.cmd)
					CMD_LOAD: begin
						if (stat.a_ok) dcmd.op = OP_LOAD;
						state_d = S_FINISH;
					end
					CMD_TRI: begin
						if (stat.tri_ok) begin
							state_d = S_FETCH;
						end else begin
							dcmd.op = OP_SKIP;
							state_d = S_FINISH;
						end
					end
					CMD_READ: state_d = stat.a_ok ? S_SRD : S_FINISH;
					default:  state_d = S_FINISH;
				endcase
			end
			S_FETCH: begin
				dcmd.op = cnt_q[0] ? OP_LATCH : OP_FETCH;
				dcmd.k  = cnt_q[2:1];
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(5)) state_d = S_DIFF;
			end
			S_DIFF: begin
				dcmd.op = OP_DIFF;
				cnt_d   = '0;
				state_d = S_MUL;
			end
			S_MUL: begin
				dcmd.op = cnt_q[0] ? OP_SUB : OP_MUL;
				dcmd.k  = cnt_q[2:1];
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(7)) state_d = S_CHKDET;
			end
			S_CHKDET: begin
				comp_d = '0;
				if (stat.det_zero) begin
					dcmd.op = OP_SKIP;
					state_d = S_FINISH;
				end else begin
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				dcmd.op = OP_DINIT;
				dcmd.k  = comp_q;
				cnt_d   = '0;
				state_d = S_DSTEP;
			end
			S_DSTEP: begin
				dcmd.op = OP_DSTEP;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_DEND;
			end
			S_DEND: begin
				dcmd.op = OP_DEND;
				dcmd.k  = comp_q;
				cnt_d   = '0;
				if (comp_q == 2'd2) begin
					state_d = S_ACC;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = S_DINIT;
				end
			end
			S_ACC: begin
				dcmd.op = cnt_q[0] ? OP_AWR : OP_ARD;
				dcmd.k  = cnt_q[2:1];
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(5)) state_d = S_FINISH;
			end
			S_SRD: begin
				dcmd.op = OP_SRD;
				state_d = S_SCAP;
			end
			S_SCAP: begin
				dcmd.op = OP_SCAP;
				cnt_d   = '0;
				state_d = S_SQ;
			end
			S_SQ: begin
				dcmd.op = cnt_q[0] ? OP_LSUM : OP_SQ;
				dcmd.k  = cnt_q[2:1];
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(5)) state_d = S_CHKLEN;
			end
			S_CHKLEN: begin
				comp_d = '0;
				if (stat.len_zero) begin
					dcmd.op = OP_ZERO;
					state_d = S_FINISH;
				end else begin
					state_d = S_NINIT;
				end
			end
			S_NINIT: begin
				dcmd.op = OP_NINIT;
				dcmd.k  = comp_q;
				cnt_d   = '0;
				state_d = S_NSTEP;
			end
			S_NSTEP: begin
				dcmd.op = OP_NSTEP;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAC_STEPS - 1)) state_d = S_RINIT;
			end
			S_RINIT: begin
				dcmd.op = OP_RINIT;
				cnt_d   = '0;
				state_d = S_RSTEP;
			end
			S_RSTEP: begin
				dcmd.op = OP_RSTEP;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = S_REND;
			end
			S_REND: begin
				dcmd.op = OP_REND;
				dcmd.k  = comp_q;
				if (comp_q == 2'd2) begin
					state_d = S_FINISH;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = S_NINIT;
				end
			end
			S_FINISH: begin
				dcmd.op = OP_FINISH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

### hdl/mtg_dp.sv
`default_nettype none
module mtg_dp
	import mtg_pkg::*;
#(
	parameter int MAX_VERTICES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           dcmd,
	output dp_stat_t               stat,
	input  wire logic [1:0]        cmd,
	input  wire logic [IDX_W-1:0]  vertex_index,
	input  wire logic [IDX_W-1:0]  corner_b,
	input  wire logic [IDX_W-1:0]  corner_c,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic signed [15:0] tex_u,
	input  wire logic signed [15:0] tex_v,
	output logic                   done,
	output logic signed [15:0]     tan_x,
	output logic signed [15:0]     tan_y,
	output logic signed [15:0]     tan_z,
	output logic [1:0]             status
);

	localparam int DEPTH = (MAX_VERTICES > (1 << IDX_W)) ? (1 << IDX_W) : MAX_VERTICES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic signed [16:0] sub17(input logic [15:0] a, input logic [15:0] b);
		sub17 = $signed({a[15], a}) - $signed({b[15], b});
	endfunction

	function automatic logic [34:0] abs35(input logic signed [34:0] x);
		abs35 = x[34] ? 35'(-x) : x;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		else                sat_add = s[31:0];
	endfunction

	// captured item
	logic [1:0]       cmd_q;
	logic [IDX_W-1:0] ia_q, ib_q, ic_q;
	logic [47:0]      pos_in_q;
	logic [31:0]      tex_in_q;

	// vertex stores
	logic [47:0] pos_mem [DEPTH];
	logic [31:0] tex_mem [DEPTH];
	logic [95:0] sum_mem [DEPTH];
	logic [47:0] pos_rd_q;
	logic [31:0] tex_rd_q;
	logic [95:0] sum_rd_q;

	// triangle datapath
	logic [47:0] pv_q [3];
	logic [31:0] tv_q [3];
	logic signed [16:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [33:0] p1_q, p2_q;
	logic signed [34:0] det_q;
	logic signed [34:0] num_q [3];
	logic [35:0] drem_q;
	logic [32:0] dlo_q;
	logic [34:0] dden_q;
	logic        dneg_q, dovf_q;
	logic [31:0] t_q [3];

	// normalise datapath
	logic        sneg_q [3];
	logic [31:0] mag_q [3];
	logic [63:0] sq_q [3];
	logic [63:0] len_q, rem_q;
	logic [28:0] fq_q;
	logic        fsat_q;
	logic [29:0] rv_q, rres_q, rbit_q;

	logic signed [15:0] tan_q [3];
	logic [1:0]  stat_q;
	logic        done_q;

	logic [IDX_W-1:0] idx_k;
	logic [AW-1:0]    addr_k, addr_a;
	logic signed [16:0] mx, my;
	logic [54:0] nmag;
	logic [34:0] dmag;
	logic [35:0] drem2;
	logic [64:0] rem2;
	logic [29:0] rtry;
	logic [31:0] qmag;
	logic [95:0] sum_new;

	always_comb begin
		case (dcmd.k)
			2'd0:    idx_k = ia_q;
			2'd1:    idx_k = ib_q;
			default: idx_k = ic_q;
		endcase
	end
	assign addr_k = idx_k[AW-1:0];
	assign addr_a = ia_q[AW-1:0];

	assign stat.cmd      = cmd_q;
	assign stat.a_ok     = (32'(ia_q) < 32'(MAX_VERTICES));
	assign stat.tri_ok   = stat.a_ok && (32'(ib_q) < 32'(MAX_VERTICES))
	                       && (32'(ic_q) < 32'(MAX_VERTICES));
	assign stat.det_zero = (det_q == '0);
	assign stat.len_zero = (len_q == '0);

	always_comb begin
		if (dcmd.k == 2'd0) begin
			mx = du1_q;
			my = du2_q;
		end else begin
			mx = e1_q[dcmd.k - 2'd1];
			my = e2_q[dcmd.k - 2'd1];
		end
	end

	assign nmag  = {abs35(num_q[dcmd.k]), 20'd0};
	assign dmag  = abs35(det_q);
	assign drem2 = {drem_q[34:0], dlo_q[32]};
	assign rem2  = {rem_q, 1'b0};
	assign rtry  = rres_q + rbit_q;
	assign qmag  = dlo_q[31:0];
	assign sum_new = {sat_add(sum_rd_q[95:64], t_q[2]), sat_add(sum_rd_q[63:32], t_q[1]),
	                  sat_add(sum_rd_q[31:0], t_q[0])};

	// stores: one port each, read data registered
	always_ff @(posedge clk) begin
		if (dcmd.op == OP_LOAD) begin
			pos_mem[addr_a] <= pos_in_q;
			tex_mem[addr_a] <= tex_in_q;
		end
		if (dcmd.op == OP_FETCH) begin
			pos_rd_q <= pos_mem[addr_k];
			tex_rd_q <= tex_mem[addr_k];
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.op == OP_LOAD)     sum_mem[addr_a] <= '0;
		else if (dcmd.op == OP_AWR) sum_mem[addr_k] <= sum_new;
		if (dcmd.op == OP_ARD)      sum_rd_q <= sum_mem[addr_k];
		else if (dcmd.op == OP_SRD) sum_rd_q <= sum_mem[addr_a];
	end

	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_CAPTURE: begin
				cmd_q    <= cmd;
				ia_q     <= vertex_index;
				ib_q     <= corner_b;
				ic_q     <= corner_c;
				pos_in_q <= {pos_z, pos_y, pos_x};
				tex_in_q <= {tex_v, tex_u};
				tan_q[0] <= '0;
				tan_q[1] <= '0;
				tan_q[2] <= '0;
				stat_q   <= STAT_OK;
			end
			OP_LATCH: begin
				pv_q[dcmd.k] <= pos_rd_q;
				tv_q[dcmd.k] <= tex_rd_q;
			end
			OP_DIFF: begin
				du1_q <= sub17(tv_q[2][15:0], tv_q[0][15:0]);
				dv1_q <= sub17(tv_q[2][31:16], tv_q[0][31:16]);
				du2_q <= sub17(tv_q[1][15:0], tv_q[0][15:0]);
				dv2_q <= sub17(tv_q[1][31:16], tv_q[0][31:16]);
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= sub17(pv_q[2][16*i +: 16], pv_q[0][16*i +: 16]);
					e2_q[i] <= sub17(pv_q[1][16*i +: 16], pv_q[0][16*i +: 16]);
				end
			end
			OP_MUL: begin
				p1_q <= mx * dv2_q;
				p2_q <= my * dv1_q;
			end
			OP_SUB: begin
				if (dcmd.k == 2'd0) det_q <= $signed({p1_q[33], p1_q}) - $signed({p2_q[33], p2_q});
				else num_q[dcmd.k - 2'd1] <= $signed({p1_q[33], p1_q})
				                             - $signed({p2_q[33], p2_q});
			end
			OP_DINIT: begin
				dden_q <= dmag;
				dneg_q <= num_q[dcmd.k][34] ^ det_q[34];
				dovf_q <= ({13'd0, nmag[54:33]} >= dmag);
				drem_q <= {14'd0, nmag[54:33]};
				dlo_q  <= nmag[32:0];
			end
			OP_DSTEP: begin
				if (drem2 >= {1'b0, dden_q}) begin
					drem_q <= drem2 - {1'b0, dden_q};
					dlo_q  <= {dlo_q[31:0], 1'b1};
				end else begin
					drem_q <= drem2;
					dlo_q  <= {dlo_q[31:0], 1'b0};
				end
			end
			OP_DEND: begin
				if (dovf_q || dlo_q[32] || dlo_q[31]) t_q[dcmd.k] <= dneg_q ? 32'h8000_0000 : 32'h7fff_ffff;
				else t_q[dcmd.k] <= dneg_q ? (32'd0 - qmag) : qmag;
			end
			OP_SCAP: begin
				for (int i = 0; i < 3; i++) begin
					sneg_q[i] <= sum_rd_q[32*i + 31];
					mag_q[i]  <= sum_rd_q[32*i + 31] ? (32'd0 - sum_rd_q[32*i +: 32])
					                                 : sum_rd_q[32*i +: 32];
				end
				len_q <= '0;
			end
			OP_SQ:   sq_q[dcmd.k] <= mag_q[dcmd.k] * mag_q[dcmd.k];
			OP_LSUM: len_q <= len_q + sq_q[dcmd.k];
			OP_NINIT: begin
				rem_q <= sq_q[dcmd.k];
				if (sq_q[dcmd.k] >= len_q) begin
					fsat_q <= 1'b1;
					fq_q   <= 29'h1000_0000;
				end else begin
					fsat_q <= 1'b0;
					fq_q   <= '0;
				end
			end
			OP_NSTEP: begin
				if (!fsat_q) begin
					if (rem2 >= {1'b0, len_q}) begin
						rem_q <= 64'(rem2 - {1'b0, len_q});
						fq_q  <= {fq_q[27:0], 1'b1};
					end else begin
						rem_q <= rem2[63:0];
						fq_q  <= {fq_q[27:0], 1'b0};
					end
				end
			end
			OP_RINIT: begin
				rv_q   <= {1'b0, fq_q};
				rres_q <= '0;
				rbit_q <= 30'h1000_0000;
			end
			OP_RSTEP: begin
				if (rv_q >= rtry) begin
					rv_q   <= rv_q - rtry;
					rres_q <= (rres_q >> 1) + rbit_q;
				end else begin
					rres_q <= rres_q >> 1;
				end
				rbit_q <= rbit_q >> 2;
			end
			// root is at most 16384, so keep bit 14
			OP_REND: tan_q[dcmd.k] <= sneg_q[dcmd.k] ? (16'sd0 - $signed(rres_q[15:0]))
			                                         : $signed(rres_q[15:0]);
			OP_SKIP: stat_q <= STAT_DEGEN;
			OP_ZERO: stat_q <= STAT_ZERO;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= (dcmd.op == OP_FINISH);
	end

	assign done   = done_q;
	assign tan_x  = tan_q[0];
	assign tan_y  = tan_q[1];
	assign tan_z  = tan_q[2];
	assign status = stat_q;

endmodule
`default_nettype wire

### hdl/mesh_tangent_generator.sv
`default_nettype none
// Per-vertex tangent generator. Pulse start with an item while busy is low; busy rises on
// the next edge and stays high until the item is finished. Every item gives exactly one
// result: done is high for one cycle with tan_x/y/z and status, and the receiver cannot
// stall it, so capture the beat on that cycle or lose it. A triangle's time is set by the
// shift-subtract divider that produces each tangent component one quotient bit a cycle
// (33 bits, three times). A read's time is set by the normalise unit: 28 fraction bits
// of |c|^2/L then 15 root digits, once per component. Skipped triangles and zero-length
// reads return early, without the divide or the normalise. Vertex, texcoord and sum
// stores are not cleared on reset: load a vertex before using it in a triangle or read.
module mesh_tangent_generator
	import mtg_pkg::*;
#(
	parameter int MAX_VERTICES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        cmd,
	input  wire logic [IDX_W-1:0]  vertex_index,
	input  wire logic [IDX_W-1:0]  corner_b,
	input  wire logic [IDX_W-1:0]  corner_c,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic signed [15:0] tex_u,
	input  wire logic signed [15:0] tex_v,
	output logic                   done,
	output logic signed [15:0]     tan_x,
	output logic signed [15:0]     tan_y,
	output logic signed [15:0]     tan_z,
	output logic [1:0]             status
);

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	// sequencer: decode the item, step the datapath through fetch, divide, accumulate, normalise
	mtg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dstat),
		.dcmd   (dcmd),
		.busy   (busy)
	);

	// stores, multipliers, divider and root unit
	mtg_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dcmd         (dcmd),
		.stat         (dstat),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.done         (done),
		.tan_x        (tan_x),
		.tan_y        (tan_y),
		.tan_z        (tan_z),
		.status       (status)
	);

endmodule
`default_nettype wire

### hdl/mtg_chk.sv
`default_nettype none
module mtg_chk
	import mtg_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic signed [15:0] tan_x,
	input wire logic signed [15:0] tan_y,
	input wire logic signed [15:0] tan_z,
	input wire logic [1:0]        status
);

	// a taken item keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");

	// busy drops exactly as the result beat appears
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy fell without a result beat");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == STAT_OK || status == STAT_DEGEN || status == STAT_ZERO)
		else $error("unused status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> tan_x == 16'sd0 && tan_y == 16'sd0 && tan_z == 16'sd0)
		else $error("non-zero tangent on a failed item");

endmodule

bind mesh_tangent_generator mtg_chk u_mtg_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.tan_x  (tan_x),
	.tan_y  (tan_y),
	.tan_z  (tan_z),
	.status (status)
);
`default_nettype wire
